>>> src/ckfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckfr_pkg
// Shared types and constants for the checksum frame receiver: the deframer
// phase encoding and the per-byte result record.
// ----------------------------------------------------------------------------
package ckfr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned SumW   = 16;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned OutUserW = 2;

  // Position within a frame.
  typedef enum logic [1:0] {
    PH_LENGTH  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CK_HIGH = 2'd2,
    PH_CK_LOW  = 2'd3
  } ckfr_phase_t;

  // One result per received byte.
  typedef struct packed {
    logic             payload_valid;
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] payload_index;
    logic             frame_done;
    logic             frame_ok;
    logic [ByteW-1:0] frame_length;
  } ckfr_result_t;

endpackage

>>> src/ckfr_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckfr_in_stage
// Input register for received bytes. It accepts a new transaction whenever
// it is empty or its current byte is moving on in the same cycle.
// ----------------------------------------------------------------------------
module ckfr_in_stage
  import ckfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [InDataW-1:0] s_axis_tdata,
  input  logic               advance,
  output logic               held_valid,
  output logic [ByteW-1:0]   held_byte
);

  logic full;
  logic [ByteW-1:0] byte_q;

  assign s_axis_tready = !full || advance;
  assign held_valid    = full;
  assign held_byte     = byte_q;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (s_axis_tready) begin
      full <= s_axis_tvalid;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      byte_q <= s_axis_tdata[ByteW-1:0];
    end
  end

endmodule

>>> src/ckfr_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckfr_deframer
// Frame state and checksum accumulator. Computes the result for the held
// byte combinationally and updates its state when the byte is consumed.
// ----------------------------------------------------------------------------
module ckfr_deframer
  import ckfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [ByteW-1:0] rx_byte,
  output ckfr_result_t     result
);

  ckfr_phase_t      phase, phase_next;
  logic [ByteW-1:0] expected_length, expected_length_next;
  logic [ByteW-1:0] bytes_seen, bytes_seen_next;
  logic [SumW-1:0]  running_sum, running_sum_next;
  logic [ByteW-1:0] checksum_high, checksum_high_next;
  logic [ByteW-1:0] seen_inc;

  assign seen_inc = bytes_seen + ByteW'(1);

  // Next state and result for the byte at the input.
  always_comb begin
    phase_next           = phase;
    expected_length_next = expected_length;
    bytes_seen_next      = bytes_seen;
    running_sum_next     = running_sum;
    checksum_high_next   = checksum_high;
    result               = '0;
    unique case (phase)
      PH_LENGTH: begin
        expected_length_next = rx_byte;
        bytes_seen_next      = '0;
        running_sum_next     = '0;
        phase_next           = (rx_byte == '0) ? PH_CK_HIGH : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        result.payload_valid = 1'b1;
        result.payload_byte  = rx_byte;
        result.payload_index = bytes_seen;
        running_sum_next     = running_sum + {{(SumW-ByteW){1'b0}}, rx_byte};
        bytes_seen_next      = seen_inc;
        if (seen_inc == expected_length) begin
          phase_next = PH_CK_HIGH;
        end
      end
      PH_CK_HIGH: begin
        checksum_high_next = rx_byte;
        phase_next         = PH_CK_LOW;
      end
      PH_CK_LOW: begin
        result.frame_done = 1'b1;
        result.frame_ok   = ({checksum_high, rx_byte} == running_sum);
        result.frame_length = expected_length;
        bytes_seen_next   = '0;
        running_sum_next  = '0;
        phase_next        = PH_LENGTH;
      end
      default: begin
        phase_next = PH_LENGTH;
      end
    endcase
  end

  // State registers, updated once per consumed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_LENGTH;
      expected_length <= '0;
      bytes_seen      <= '0;
      running_sum     <= '0;
      checksum_high   <= '0;
    end else if (step) begin
      phase           <= phase_next;
      expected_length <= expected_length_next;
      bytes_seen      <= bytes_seen_next;
      running_sum     <= running_sum_next;
      checksum_high   <= checksum_high_next;
    end
  end

endmodule

>>> src/ckfr_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckfr_out_stage
// Result register. Packs the result record onto the output stream and
// holds it until the downstream side takes the transaction.
// ----------------------------------------------------------------------------
module ckfr_out_stage
  import ckfr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                held_valid,
  input  ckfr_result_t        result,
  output logic                advance,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic [OutUserW-1:0] m_axis_tuser
);

  logic         full;
  ckfr_result_t res_q;

  // A held byte moves on when the result slot is free or being emptied.
  assign advance       = held_valid && (!full || m_axis_tready);
  assign m_axis_tvalid = full;

  // tdata: payload_byte, payload_index, frame_ok, frame_length, zero fill.
  assign m_axis_tdata = {7'b0, res_q.frame_length, res_q.frame_ok,
                         res_q.payload_index, res_q.payload_byte};
  // tuser: payload_valid, frame_done.
  assign m_axis_tuser = {res_q.frame_done, res_q.payload_valid};

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (advance) begin
      full <= 1'b1;
    end else if (m_axis_tready) begin
      full <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= result;
    end
  end

endmodule

>>> src/checksum_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksum_frame_receiver
// Deframes length-prefixed frames with a 16-bit additive checksum.
// ----------------------------------------------------------------------------
//   Stream    Dir  tdata                       tuser
//   s_axis    in   rx_byte                     -
//   m_axis    out  payload byte/index, status  payload_valid, frame_done
//
// One result per received byte, one byte per cycle sustained while m_axis is not stalled.
// The result shows on m_axis after the input transaction: the
// input register holds the byte, and the deframer logic loads the result
// register when the held byte moves on.
// A stall on m_axis fills both registers, then drops s_axis_tready.
// rst is synchronous and returns the deframer to waiting for a length byte.
// ----------------------------------------------------------------------------
module checksum_frame_receiver
  import ckfr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] payload_byte, [15:8] payload_index, [16] frame_ok,
  // [24:17] frame_length, [31:25] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic [OutUserW-1:0] m_axis_tuser    // [0] payload_valid, [1] frame_done
);

  logic             advance;
  logic             held_valid;
  logic [ByteW-1:0] held_byte;
  ckfr_result_t     result;

  // Input register.
  ckfr_in_stage u_in (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .advance       (advance),
    .held_valid    (held_valid),
    .held_byte     (held_byte)
  );

  // Frame state machine and checksum.
  ckfr_deframer u_deframer (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (held_byte),
    .result  (result)
  );

  // Result register.
  ckfr_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .held_valid    (held_valid),
    .result        (result),
    .advance       (advance),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

>>> src/ckfr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckfr_checker
// Port-level checks for the checksum frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module ckfr_checker
  import ckfr_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [InDataW-1:0]  s_axis_tdata,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [OutUserW-1:0] m_axis_tuser
);

  // An input transaction that is not yet taken holds.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata))
    else $error("input changed while waiting");

  // A stalled result transaction holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A byte is never both payload and the end of a frame.
  a_kind_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("payload and frame end flagged together");

  // Payload fields are zero unless a payload byte is reported.
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[15:0] == 16'h0)
    else $error("payload fields set without payload_valid");

  // Frame status is zero unless a frame end is reported.
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[31:16] == 16'h0)
    else $error("frame status set without frame_done");

endmodule

bind checksum_frame_receiver ckfr_checker u_ckfr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
